// ===== rtl/bpam_pkg.sv =====
package bpam_pkg;

  // Sizes of the pattern vectors and the symbol table
  localparam int PATTERN_BITS  = 64;
  localparam int ALPHABET_SIZE = 128;

  // Fixed field widths
  localparam int SYM_W   = 7;
  localparam int MASK_W  = 64;
  localparam int LEN_W   = 7;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 7;
  localparam int ADDR_W  = $clog2(ALPHABET_SIZE);
  localparam int TOP_W   = $clog2(PATTERN_BITS);

  // Item function codes
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_TEXT  = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_MAX_ERRORS     = 1'b1
  } cfg_idx_t;

  typedef logic [PATTERN_BITS-1:0] vec_t;

  // Access request to the mask table
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    vec_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } tbl_req_t;

endpackage

// ===== rtl/bpam_table.sv =====
module bpam_table
  import bpam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tbl_req_t req,
  output vec_t     rd_mask
);

  // Mask storage, one write and one registered read per cycle
  vec_t                     mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] written;
  vec_t                     rd_raw;
  logic                     rd_written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // Per-entry written flags give the all-zero reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[req.rd_addr];
      end
    end
  end

  assign rd_mask = rd_written ? rd_raw : '0;

endmodule

// ===== rtl/bit_parallel_approximate_matcher.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+--------------------------------------
// item     | item_valid / item_stall  | func, symbol, mask_bits
// result   | result_valid / result_stall | match_found, distance, position
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle while item_stall is low. A text symbol reads its mask from the
// table at the accept edge, updates the vectors and score as it leaves the update
// stage and loads its result into the output register at that same edge.
// Reset clears the table's written flags at once; no clearing pass.
// A result held under result_stall stalls a text item in the update stage,
// which stalls the item channel only while that stage holds such an item.
module bit_parallel_approximate_matcher
  import bpam_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        func,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [MASK_W-1:0] mask_bits,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output logic              match_found,
  output logic [LEN_W-1:0]  distance,
  output logic [POS_W-1:0]  position,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // Configuration registers
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] max_errors;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      max_errors     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data;
        CFG_MAX_ERRORS:     max_errors     <= cfg_data;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid;
  logic s1_text;
  logic s1_start;
  logic s1_go;
  logic out_free;
  logic accept;
  logic sym_ok;

  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_text || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign accept     = item_valid && !item_stall;
  assign sym_ok     = (9'(symbol) < 9'(ALPHABET_SIZE));

  // Table access at the accept edge
  tbl_req_t req;
  vec_t     eq;

  always_comb begin
    req.wr_en   = accept && (func == FN_LOAD) && sym_ok;
    req.wr_addr = ADDR_W'(symbol);
    req.wr_data = mask_bits[PATTERN_BITS-1:0];
    req.rd_en   = accept && (func == FN_TEXT);
    req.rd_addr = ADDR_W'(symbol);
  end

  bpam_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_mask (eq)
  );

  // Out-of-range symbols match nothing
  logic s1_sym_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_text   <= 1'b0;
      s1_start  <= 1'b0;
      s1_sym_ok <= 1'b0;
    end else if (!s1_valid || s1_go) begin
      s1_valid  <= accept && ((func == FN_TEXT) || (func == FN_START));
      s1_text   <= (func == FN_TEXT);
      s1_start  <= (func == FN_START);
      s1_sym_ok <= sym_ok;
    end
  end

  // Effective pattern length, clamped to 1..PATTERN_BITS
  logic [LEN_W-1:0] len_eff;
  logic [TOP_W-1:0] top_idx;

  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(PATTERN_BITS)) begin
      len_eff = LEN_W'(PATTERN_BITS);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign top_idx = TOP_W'(len_eff - LEN_W'(1));

  // Search state
  vec_t             plus_vec;
  vec_t             minus_vec;
  logic [LEN_W-1:0] score;
  logic [POS_W-1:0] text_pos;

  // Bit-vector column update
  vec_t             eq_m, xh, xv, ph, mh, ph_sh, mh_sh;
  vec_t             plus_vec_next, minus_vec_next;
  logic [LEN_W-1:0] score_next;

  always_comb begin
    eq_m = s1_sym_ok ? eq : '0;
    xh   = (((eq_m & plus_vec) + plus_vec) ^ plus_vec) | eq_m;
    xv   = eq_m | minus_vec;
    ph   = minus_vec | ~(xh | plus_vec);
    mh   = plus_vec & xh;

    // Score follows the top pattern position in use, saturating
    score_next = score;
    priority if (ph[top_idx]) begin
      if (score != '1) score_next = score + LEN_W'(1);
    end else if (mh[top_idx]) begin
      if (score != '0) score_next = score - LEN_W'(1);
    end else begin
      score_next = score;
    end

    ph_sh          = ph << 1;
    mh_sh          = mh << 1;
    plus_vec_next  = mh_sh | ~(xv | ph_sh);
    minus_vec_next = ph_sh & xv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_vec  <= '1;
      minus_vec <= '0;
      score     <= LEN_W'(1);
      text_pos  <= '0;
    end else if (s1_go) begin
      if (s1_start) begin
        plus_vec  <= '1;
        minus_vec <= '0;
        score     <= len_eff;
        text_pos  <= '0;
      end else if (s1_text) begin
        plus_vec  <= plus_vec_next;
        minus_vec <= minus_vec_next;
        score     <= score_next;
        text_pos  <= text_pos + POS_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_text) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_text) begin
      match_found <= (score_next <= max_errors);
      distance    <= score_next;
      position    <= text_pos + POS_W'(1);
    end
  end

  // Checks
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_text && result_valid))
    else $error("item stall without a held result");

  a_vectors_disjoint: assert property (@(posedge clk) disable iff (rst)
    (plus_vec & minus_vec) == '0)
    else $error("plus and minus vectors overlap");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_start) |=> (plus_vec == '1 && minus_vec == '0 && text_pos == '0))
    else $error("start item did not reset search state");

  a_text_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_text) |=> (result_valid && position == text_pos
                            && distance == score))
    else $error("text item result does not match search state");

endmodule
